// File: rtl/core/iets_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C EEPROM transaction sequencer package
// Shared codes, types, reset values and the page boundary table builder.
// ----------------------------------------------------------------------------

package iets_pkg;

  localparam int unsigned PAGE_BYTES_DEFAULT = 8;
  localparam logic [7:0]  DEV_ADDR_RESET     = 8'd160;
  localparam logic [15:0] POLL_LIMIT_RESET   = 16'd1000;
  localparam logic [8:0]  MAX_COUNT          = 9'd256;
  localparam int unsigned MAX_RESULTS        = 3;

  typedef enum logic [2:0] {
    MODE_PROBE = 3'd0,
    MODE_READ  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_DATA  = 3'd3,
    MODE_RESP  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_SEND      = 3'd3,
    CMD_RECV_ACK  = 3'd4,
    CMD_RECV_NACK = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_PROBE_ACK    = 4'd1,
    PH_RD_DEV_ACK   = 4'd2,
    PH_RD_WORD_ACK  = 4'd3,
    PH_RD_DEV2_ACK  = 4'd4,
    PH_RD_DATA      = 4'd5,
    PH_WR_WAIT_DATA = 4'd6,
    PH_WR_POLL      = 4'd7,
    PH_WR_WORD_ACK  = 4'd8,
    PH_WR_DATA_ACK  = 4'd9
  } phase_e;

  typedef enum logic {
    CFG_DEV_ADDR   = 1'b0,
    CFG_POLL_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] cmd_byte;
    logic       rd_valid;
    logic [7:0] rd_value;
    logic       need_data;
    logic       done;
    logic       success;
    logic       last;
  } res_t;

  // Marks every 8-bit word address that starts a page.
  function automatic logic [255:0] page_start_map(int unsigned page_bytes);
    logic [255:0] m;
    int unsigned  k;
    m = '0;
    k = 0;
    for (int i = 0; i < 256; i++) begin
      m[i] = (k == 0);
      k++;
      if (k == page_bytes) begin
        k = 0;
      end
    end
    return m;
  endfunction

endpackage

// File: rtl/core/i2c_eeprom_transaction_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C EEPROM transaction sequencer
// Turns probe, read and write requests into byte-level I2C bus commands.
// ----------------------------------------------------------------------------
// The input channel carries requests, write data bytes and bus responses; the
// output channel carries one bus command per transaction, together with read
// data, data requests and the completion status. Both channels use valid and
// stall. The user must write registers through the cfg port only while the
// block is idle (not enforced). An accepted input updates the sequencer state
// in the same edge and loads the zero to three results it causes into a small
// result buffer; the first result is offered on the next cycle. An input
// causing one result lets inputs follow at one input per cycle unless the
// receiver stalls. An input causing n results occupies the buffer for n output
// transactions, and a new input is taken in the cycle its last result leaves.
// When the receiver stalls, the buffer holds and the input side stalls once
// the buffer is not about to empty. Reset returns the sequencer to idle and
// restores the device address to 160 and the polling limit to 1000.
// ----------------------------------------------------------------------------

module i2c_eeprom_transaction_sequencer #(
  parameter int unsigned PAGE_BYTES = iets_pkg::PAGE_BYTES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  address_i,
  input  logic [8:0]  byte_count_i,
  input  logic [7:0]  data_byte_i,
  input  logic        nack_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  bus_command_o,
  output logic [7:0]  command_byte_o,
  output logic        read_valid_o,
  output logic [7:0]  read_value_o,
  output logic        need_data_o,
  output logic        done_res_o,
  output logic        success_o,
  output logic        last_o
);

  localparam logic [255:0] PageStartMap = iets_pkg::page_start_map(PAGE_BYTES);

  logic [6:0]  dev_addr_q;
  logic [15:0] poll_limit_q;

  iets_pkg::phase_e phase_q, phase_d;
  logic [7:0]  cur_addr_q, cur_addr_d;
  logic [8:0]  bytes_left_q, bytes_left_d;
  logic [7:0]  held_q, held_d;
  logic [15:0] poll_q, poll_d;
  logic        first_q, first_d;

  iets_pkg::res_t res_q [iets_pkg::MAX_RESULTS];
  iets_pkg::res_t res_d [iets_pkg::MAX_RESULTS];
  logic [1:0]  cnt_q;
  logic [1:0]  nres;

  logic        accept;
  logic        take;
  logic [8:0]  count;
  logic        page_start;
  logic [8:0]  bl_dec;
  logic [7:0]  dev_w;
  logic [7:0]  dev_r;
  iets_pkg::mode_e mode;

  assign mode       = iets_pkg::mode_e'(mode_i);
  assign count      = (byte_count_i > iets_pkg::MAX_COUNT) ? iets_pkg::MAX_COUNT : byte_count_i;
  assign page_start = PageStartMap[cur_addr_q];
  assign bl_dec     = (bytes_left_q != 9'd0) ? bytes_left_q - 9'd1 : bytes_left_q;
  assign dev_w      = {dev_addr_q, 1'b0};
  assign dev_r      = {dev_addr_q, 1'b1};

  assign out_valid_o = (cnt_q != 2'd0);
  assign take        = out_valid_o && !out_stall_i;
  assign in_stall_o  = (cnt_q > 2'd1) || ((cnt_q == 2'd1) && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= iets_pkg::DEV_ADDR_RESET[7:1];
      poll_limit_q <= iets_pkg::POLL_LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (iets_pkg::cfg_idx_e'(cfg_addr_i))
        iets_pkg::CFG_DEV_ADDR:   dev_addr_q   <= cfg_wdata_i[7:1];
        iets_pkg::CFG_POLL_LIMIT: poll_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d      = phase_q;
    cur_addr_d   = cur_addr_q;
    bytes_left_d = bytes_left_q;
    held_d       = held_q;
    poll_d       = poll_q;
    first_d      = first_q;
    if (accept) begin
      unique case (mode)
        iets_pkg::MODE_PROBE, iets_pkg::MODE_READ, iets_pkg::MODE_WRITE: begin
          if (phase_q == iets_pkg::PH_IDLE) begin
            if (mode == iets_pkg::MODE_PROBE) begin
              phase_d = iets_pkg::PH_PROBE_ACK;
            end else if (count != 9'd0) begin
              cur_addr_d   = address_i;
              bytes_left_d = count;
              if (mode == iets_pkg::MODE_READ) begin
                phase_d = iets_pkg::PH_RD_DEV_ACK;
              end else begin
                first_d = 1'b1;
                phase_d = iets_pkg::PH_WR_WAIT_DATA;
              end
            end
          end
        end
        iets_pkg::MODE_DATA: begin
          if (phase_q == iets_pkg::PH_WR_WAIT_DATA) begin
            held_d = data_byte_i;
            if (first_q || page_start) begin
              poll_d  = 16'd1;
              phase_d = iets_pkg::PH_WR_POLL;
            end else begin
              phase_d = iets_pkg::PH_WR_DATA_ACK;
            end
          end
        end
        iets_pkg::MODE_RESP: begin
          unique case (phase_q)
            iets_pkg::PH_PROBE_ACK: phase_d = iets_pkg::PH_IDLE;
            iets_pkg::PH_RD_DEV_ACK:
              phase_d = nack_i ? iets_pkg::PH_IDLE : iets_pkg::PH_RD_WORD_ACK;
            iets_pkg::PH_RD_WORD_ACK:
              phase_d = nack_i ? iets_pkg::PH_IDLE : iets_pkg::PH_RD_DEV2_ACK;
            iets_pkg::PH_RD_DEV2_ACK:
              phase_d = nack_i ? iets_pkg::PH_IDLE : iets_pkg::PH_RD_DATA;
            iets_pkg::PH_RD_DATA: begin
              bytes_left_d = bl_dec;
              if (bl_dec == 9'd0) begin
                phase_d = iets_pkg::PH_IDLE;
              end
            end
            iets_pkg::PH_WR_POLL: begin
              if (!nack_i) begin
                phase_d = iets_pkg::PH_WR_WORD_ACK;
              end else if (poll_q >= poll_limit_q) begin
                phase_d = iets_pkg::PH_IDLE;
              end else begin
                poll_d = poll_q + 16'd1;
              end
            end
            iets_pkg::PH_WR_WORD_ACK:
              phase_d = nack_i ? iets_pkg::PH_IDLE : iets_pkg::PH_WR_DATA_ACK;
            iets_pkg::PH_WR_DATA_ACK: begin
              if (nack_i) begin
                phase_d = iets_pkg::PH_IDLE;
              end else begin
                cur_addr_d   = cur_addr_q + 8'd1;
                first_d      = 1'b0;
                bytes_left_d = bl_dec;
                phase_d      = (bl_dec == 9'd0) ? iets_pkg::PH_IDLE
                                                : iets_pkg::PH_WR_WAIT_DATA;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < iets_pkg::MAX_RESULTS; i++) begin
      res_d[i] = '0;
    end
    nres = 2'd0;
    unique case (mode)
      iets_pkg::MODE_PROBE, iets_pkg::MODE_READ, iets_pkg::MODE_WRITE: begin
        if (phase_q == iets_pkg::PH_IDLE) begin
          if (mode == iets_pkg::MODE_PROBE || (mode == iets_pkg::MODE_READ && count != 9'd0)) begin
            res_d[0].cmd      = iets_pkg::CMD_START;
            res_d[1].cmd      = iets_pkg::CMD_SEND;
            res_d[1].cmd_byte = dev_w;
            nres              = 2'd2;
          end else if (count == 9'd0) begin
            res_d[0].cmd     = iets_pkg::CMD_STOP;
            res_d[0].done    = 1'b1;
            res_d[0].success = 1'b1;
            nres             = 2'd1;
          end else begin
            res_d[0].need_data = 1'b1;
            nres               = 2'd1;
          end
        end
      end
      iets_pkg::MODE_DATA: begin
        if (phase_q == iets_pkg::PH_WR_WAIT_DATA) begin
          if (first_q || page_start) begin
            res_d[0].cmd      = iets_pkg::CMD_STOP;
            res_d[1].cmd      = iets_pkg::CMD_START;
            res_d[2].cmd      = iets_pkg::CMD_SEND;
            res_d[2].cmd_byte = dev_w;
            nres              = 2'd3;
          end else begin
            res_d[0].cmd      = iets_pkg::CMD_SEND;
            res_d[0].cmd_byte = data_byte_i;
            nres              = 2'd1;
          end
        end
      end
      iets_pkg::MODE_RESP: begin
        unique case (phase_q)
          iets_pkg::PH_PROBE_ACK: begin
            res_d[0].cmd     = iets_pkg::CMD_STOP;
            res_d[0].done    = 1'b1;
            res_d[0].success = !nack_i;
            nres             = 2'd1;
          end
          iets_pkg::PH_RD_DEV_ACK, iets_pkg::PH_RD_WORD_ACK, iets_pkg::PH_RD_DEV2_ACK,
          iets_pkg::PH_WR_WORD_ACK, iets_pkg::PH_WR_DATA_ACK, iets_pkg::PH_WR_POLL: begin
            if (nack_i && !(phase_q == iets_pkg::PH_WR_POLL && poll_q < poll_limit_q)) begin
              res_d[0].cmd  = iets_pkg::CMD_STOP;
              res_d[0].done = 1'b1;
              nres          = 2'd1;
            end else begin
              unique case (phase_q)
                iets_pkg::PH_RD_DEV_ACK: begin
                  res_d[0].cmd      = iets_pkg::CMD_SEND;
                  res_d[0].cmd_byte = cur_addr_q;
                  nres              = 2'd1;
                end
                iets_pkg::PH_RD_WORD_ACK: begin
                  res_d[0].cmd      = iets_pkg::CMD_START;
                  res_d[1].cmd      = iets_pkg::CMD_SEND;
                  res_d[1].cmd_byte = dev_r;
                  nres              = 2'd2;
                end
                iets_pkg::PH_RD_DEV2_ACK: begin
                  res_d[0].cmd = (bytes_left_q > 9'd1) ? iets_pkg::CMD_RECV_ACK
                                                       : iets_pkg::CMD_RECV_NACK;
                  nres         = 2'd1;
                end
                iets_pkg::PH_WR_POLL: begin
                  if (!nack_i) begin
                    res_d[0].cmd      = iets_pkg::CMD_SEND;
                    res_d[0].cmd_byte = cur_addr_q;
                    nres              = 2'd1;
                  end else begin
                    res_d[0].cmd      = iets_pkg::CMD_START;
                    res_d[1].cmd      = iets_pkg::CMD_SEND;
                    res_d[1].cmd_byte = dev_w;
                    nres              = 2'd2;
                  end
                end
                iets_pkg::PH_WR_WORD_ACK: begin
                  res_d[0].cmd      = iets_pkg::CMD_SEND;
                  res_d[0].cmd_byte = held_q;
                  nres              = 2'd1;
                end
                default: begin
                  if (bl_dec == 9'd0) begin
                    res_d[0].cmd     = iets_pkg::CMD_STOP;
                    res_d[0].done    = 1'b1;
                    res_d[0].success = 1'b1;
                  end else begin
                    res_d[0].need_data = 1'b1;
                  end
                  nres = 2'd1;
                end
              endcase
            end
          end
          iets_pkg::PH_RD_DATA: begin
            if (bl_dec == 9'd0) begin
              res_d[0].cmd     = iets_pkg::CMD_STOP;
              res_d[0].done    = 1'b1;
              res_d[0].success = 1'b1;
            end else begin
              res_d[0].cmd = (bl_dec > 9'd1) ? iets_pkg::CMD_RECV_ACK
                                             : iets_pkg::CMD_RECV_NACK;
            end
            res_d[0].rd_valid = 1'b1;
            res_d[0].rd_value = data_byte_i;
            nres              = 2'd1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    for (int i = 0; i < iets_pkg::MAX_RESULTS; i++) begin
      res_d[i].last = (2'(i) + 2'd1 == nres);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= iets_pkg::PH_IDLE;
      cur_addr_q   <= '0;
      bytes_left_q <= '0;
      held_q       <= '0;
      poll_q       <= '0;
      first_q      <= 1'b1;
      cnt_q        <= '0;
    end else begin
      phase_q      <= phase_d;
      cur_addr_q   <= cur_addr_d;
      bytes_left_q <= bytes_left_d;
      held_q       <= held_d;
      poll_q       <= poll_d;
      first_q      <= first_d;
      if (accept) begin
        cnt_q <= nres;
      end else if (take) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < iets_pkg::MAX_RESULTS; i++) begin
        res_q[i] <= res_d[i];
      end
    end else if (take) begin
      for (int i = 0; i < iets_pkg::MAX_RESULTS - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

  assign bus_command_o  = res_q[0].cmd;
  assign command_byte_o = res_q[0].cmd_byte;
  assign read_valid_o   = res_q[0].rd_valid;
  assign read_value_o   = res_q[0].rd_value;
  assign need_data_o    = res_q[0].need_data;
  assign done_res_o     = res_q[0].done;
  assign success_o      = res_q[0].success;
  assign last_o         = res_q[0].last;

endmodule
